/* hw/rtl/ememh_pkg.sv */
// types, constants and microcode table for the extended memory handle manager
package ememh_pkg;

   localparam int HANDLES_DEFAULT  = 32;
   localparam logic [15:0] TOTAL_KB_RESET = 16'd16384;
   localparam int PC_W = 5;

   // function codes
   localparam logic [7:0] CMD_VERSION     = 8'h00;
   localparam logic [7:0] CMD_REQ_HMA     = 8'h01;
   localparam logic [7:0] CMD_REL_HMA     = 8'h02;
   localparam logic [7:0] CMD_GLOBAL_ON   = 8'h03;
   localparam logic [7:0] CMD_GLOBAL_OFF  = 8'h04;
   localparam logic [7:0] CMD_LOCAL_ON    = 8'h05;
   localparam logic [7:0] CMD_LOCAL_OFF   = 8'h06;
   localparam logic [7:0] CMD_QUERY_A20   = 8'h07;
   localparam logic [7:0] CMD_QUERY_FREE  = 8'h08;
   localparam logic [7:0] CMD_ALLOC       = 8'h09;
   localparam logic [7:0] CMD_FREE        = 8'h0A;
   localparam logic [7:0] CMD_LOCK        = 8'h0C;
   localparam logic [7:0] CMD_UNLOCK      = 8'h0D;
   localparam logic [7:0] CMD_INFO        = 8'h0E;
   localparam logic [7:0] CMD_RESIZE      = 8'h0F;

   // reply codes
   localparam logic [15:0] XMS_VERSION     = 16'h0300;
   localparam logic [7:0]  ERR_BAD_FN      = 8'h80;
   localparam logic [7:0]  ERR_NO_HMA      = 8'h90;
   localparam logic [7:0]  ERR_A20_ON      = 8'h94;
   localparam logic [7:0]  ERR_NO_MEM      = 8'hA0;
   localparam logic [7:0]  ERR_NO_HANDLE   = 8'hA1;
   localparam logic [7:0]  ERR_BAD_HANDLE  = 8'hA2;
   localparam logic [7:0]  ERR_NOT_LOCKED  = 8'hAA;
   localparam logic [7:0]  INFO_FREE_BYTE  = 8'hFF;
   localparam logic [7:0]  LOCK_MAX        = 8'hFF;

   // write mask bits
   localparam logic [3:0] M_AX = 4'b0001;
   localparam logic [3:0] M_BL = 4'b0010;
   localparam logic [3:0] M_BH = 4'b0100;
   localparam logic [3:0] M_DX = 4'b1000;

   typedef enum logic [4:0] {
      U_NOP,
      U_VERSION,
      U_HMA,
      U_A20_ON,
      U_A20_OFF,
      U_QUERY_A20,
      U_QUERY_FREE,
      U_BAD_FN,
      U_TOO_BIG,
      U_FULL,
      U_BAD_HANDLE,
      U_NOT_LOCKED,
      U_IDX_CLR,
      U_IDX_INC,
      U_ALLOC,
      U_FREE,
      U_LOCK,
      U_UNLOCK,
      U_INFO,
      U_RESIZE
   } uop_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_TOO_BIG,
      C_SLOT_FREE,
      C_SCAN_LAST,
      C_FREE_BAD,
      C_BAD_HANDLE,
      C_LOCK_ZERO
   } ucond_type;

   typedef struct packed {
      uop_type           op;
      ucond_type         cond;
      logic [PC_W-1:0]   target;
      logic [PC_W-1:0]   next;
      logic              done;
   } uword_type;

   // microcode addresses
   localparam logic [PC_W-1:0] PC_VERSION    = 5'd0;
   localparam logic [PC_W-1:0] PC_HMA        = 5'd1;
   localparam logic [PC_W-1:0] PC_A20_ON     = 5'd2;
   localparam logic [PC_W-1:0] PC_A20_OFF    = 5'd3;
   localparam logic [PC_W-1:0] PC_QUERY_A20  = 5'd4;
   localparam logic [PC_W-1:0] PC_QUERY_FREE = 5'd5;
   localparam logic [PC_W-1:0] PC_BAD_FN     = 5'd6;
   localparam logic [PC_W-1:0] PC_TOO_BIG    = 5'd7;
   localparam logic [PC_W-1:0] PC_FULL       = 5'd8;
   localparam logic [PC_W-1:0] PC_BAD_HANDLE = 5'd9;
   localparam logic [PC_W-1:0] PC_NOT_LOCKED = 5'd10;
   localparam logic [PC_W-1:0] PC_ALLOC      = 5'd11;
   localparam logic [PC_W-1:0] PC_SCAN       = 5'd12;
   localparam logic [PC_W-1:0] PC_SCAN_NEXT  = 5'd13;
   localparam logic [PC_W-1:0] PC_ALLOC_WR   = 5'd14;
   localparam logic [PC_W-1:0] PC_FREE       = 5'd15;
   localparam logic [PC_W-1:0] PC_FREE_WR    = 5'd16;
   localparam logic [PC_W-1:0] PC_LOCK       = 5'd17;
   localparam logic [PC_W-1:0] PC_LOCK_WR    = 5'd18;
   localparam logic [PC_W-1:0] PC_UNLOCK     = 5'd19;
   localparam logic [PC_W-1:0] PC_UNLOCK_CHK = 5'd20;
   localparam logic [PC_W-1:0] PC_UNLOCK_WR  = 5'd21;
   localparam logic [PC_W-1:0] PC_INFO       = 5'd22;
   localparam logic [PC_W-1:0] PC_INFO_RD    = 5'd23;
   localparam logic [PC_W-1:0] PC_RESIZE     = 5'd24;
   localparam logic [PC_W-1:0] PC_RESIZE_CHK = 5'd25;
   localparam logic [PC_W-1:0] PC_RESIZE_WR  = 5'd26;

   function automatic uword_type mk_word(input uop_type op, input ucond_type cond,
                                         input logic [PC_W-1:0] target,
                                         input logic [PC_W-1:0] next,
                                         input logic done);
      uword_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      w.next   = next;
      w.done   = done;
      return w;
   endfunction

   function automatic uword_type ucode_fetch(input logic [PC_W-1:0] pc);
      uword_type w;
      unique case (pc)
         PC_VERSION:    w = mk_word(U_VERSION,    C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_HMA:        w = mk_word(U_HMA,        C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_A20_ON:     w = mk_word(U_A20_ON,     C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_A20_OFF:    w = mk_word(U_A20_OFF,    C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_QUERY_A20:  w = mk_word(U_QUERY_A20,  C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_QUERY_FREE: w = mk_word(U_QUERY_FREE, C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_TOO_BIG:    w = mk_word(U_TOO_BIG,    C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_FULL:       w = mk_word(U_FULL,       C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_BAD_HANDLE: w = mk_word(U_BAD_HANDLE, C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_NOT_LOCKED: w = mk_word(U_NOT_LOCKED, C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_ALLOC:      w = mk_word(U_IDX_CLR,    C_TOO_BIG, PC_TOO_BIG, PC_SCAN, 1'b0);
         PC_SCAN:       w = mk_word(U_NOP,        C_SLOT_FREE, PC_ALLOC_WR, PC_SCAN_NEXT,
                                    1'b0);
         PC_SCAN_NEXT:  w = mk_word(U_IDX_INC,    C_SCAN_LAST, PC_FULL, PC_SCAN, 1'b0);
         PC_ALLOC_WR:   w = mk_word(U_ALLOC,      C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_FREE:       w = mk_word(U_NOP,        C_FREE_BAD, PC_BAD_HANDLE, PC_FREE_WR,
                                    1'b0);
         PC_FREE_WR:    w = mk_word(U_FREE,       C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_LOCK:       w = mk_word(U_NOP,        C_BAD_HANDLE, PC_BAD_HANDLE, PC_LOCK_WR,
                                    1'b0);
         PC_LOCK_WR:    w = mk_word(U_LOCK,       C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_UNLOCK:     w = mk_word(U_NOP,        C_BAD_HANDLE, PC_BAD_HANDLE,
                                    PC_UNLOCK_CHK, 1'b0);
         PC_UNLOCK_CHK: w = mk_word(U_NOP,        C_LOCK_ZERO, PC_NOT_LOCKED, PC_UNLOCK_WR,
                                    1'b0);
         PC_UNLOCK_WR:  w = mk_word(U_UNLOCK,     C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_INFO:       w = mk_word(U_NOP,        C_BAD_HANDLE, PC_BAD_HANDLE, PC_INFO_RD,
                                    1'b0);
         PC_INFO_RD:    w = mk_word(U_INFO,       C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         PC_RESIZE:     w = mk_word(U_NOP,        C_TOO_BIG, PC_TOO_BIG, PC_RESIZE_CHK,
                                    1'b0);
         PC_RESIZE_CHK: w = mk_word(U_NOP,        C_BAD_HANDLE, PC_BAD_HANDLE,
                                    PC_RESIZE_WR, 1'b0);
         PC_RESIZE_WR:  w = mk_word(U_RESIZE,     C_NONE, PC_VERSION, PC_VERSION, 1'b1);
         default:       w = mk_word(U_BAD_FN,     C_NONE, PC_VERSION, PC_VERSION, 1'b1);
      endcase
      return w;
   endfunction

   function automatic logic [PC_W-1:0] dispatch(input logic [7:0] command);
      logic [PC_W-1:0] pc;
      unique case (command)
         CMD_VERSION:                   pc = PC_VERSION;
         CMD_REQ_HMA, CMD_REL_HMA:      pc = PC_HMA;
         CMD_GLOBAL_ON, CMD_LOCAL_ON:   pc = PC_A20_ON;
         CMD_GLOBAL_OFF, CMD_LOCAL_OFF: pc = PC_A20_OFF;
         CMD_QUERY_A20:                 pc = PC_QUERY_A20;
         CMD_QUERY_FREE:                pc = PC_QUERY_FREE;
         CMD_ALLOC:                     pc = PC_ALLOC;
         CMD_FREE:                      pc = PC_FREE;
         CMD_LOCK:                      pc = PC_LOCK;
         CMD_UNLOCK:                    pc = PC_UNLOCK;
         CMD_INFO:                      pc = PC_INFO;
         CMD_RESIZE:                    pc = PC_RESIZE;
         default:                       pc = PC_BAD_FN;
      endcase
      return pc;
   endfunction

endpackage

/* hw/rtl/extended_memory_handle_manager_top.sv */
// Extended memory handle manager: an accepted request runs a short microcode program, one
// step per cycle unless the last step waits on rsp_stall; req_stall is high until its reply
// word has been loaded into the output register. Version, HMA, A20, query-free and
// unknown-code replies take one step, free, lock and info two, resize and unlock two or
// three. Allocate walks the handle table entry by entry: 3 + 2k steps when entry k is the
// lowest free one, and 2 + 2*HANDLES steps when the table is full. The last step waits
// while an earlier reply is held by rsp_stall. The next request is taken the cycle after
// the last step, while that reply may still wait on rsp_stall. Block sizes and lock counts
// sit in tables with registered read, so they are used from the second step.
module extended_memory_handle_manager_top
   import ememh_pkg::*;
#(
   parameter int HANDLES = HANDLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_command,
   input  logic [15:0] req_handle,
   input  logic [15:0] req_size_kb,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_ax_out,
   output logic [7:0]  rsp_bl_out,
   output logic [7:0]  rsp_bh_out,
   output logic [15:0] rsp_dx_out,
   output logic [3:0]  rsp_write_mask,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_total_kb
);

   localparam int IDX_W = (HANDLES > 1) ? $clog2(HANDLES) : 1;
   localparam int HH_W  = $clog2(HANDLES + 1);

   logic              busy_ff;
   logic [PC_W-1:0]   pc_ff;
   logic              rsp_valid_ff;
   logic [HANDLES-1:0] valid_ff;
   logic [15:0]       used_kb_ff;
   logic [HH_W-1:0]   high_ff;
   logic [15:0]       total_kb_ff;

   logic [15:0]       handle_ff;
   logic [15:0]       size_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [15:0]       rd_size_ff;
   logic [7:0]        rd_lock_ff;

   logic [15:0]       ax_ff, dx_ff;
   logic [7:0]        bl_ff, bh_ff;
   logic [3:0]        mask_ff;
   logic [15:0]       ax_in, dx_in;
   logic [7:0]        bl_in, bh_in;
   logic [3:0]        mask_in;

   logic [15:0]       size_mem [HANDLES];
   logic [7:0]        lock_mem [HANDLES];

   uword_type         uw;
   logic              out_free;
   logic              exec;
   logic              taken;
   logic              req_take;
   logic [15:0]       free_kb;
   logic [15:0]       handle_m1;
   logic [IDX_W-1:0]  hidx;
   logic              h_in_range;
   logic [HH_W-1:0]   idx_p1;

   assign uw        = ucode_fetch(pc_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec      = busy_ff && (!uw.done || out_free);
   assign req_take  = req_valid && !busy_ff;
   assign free_kb   = (used_kb_ff > total_kb_ff) ? 16'd0 : (total_kb_ff - used_kb_ff);
   assign handle_m1 = handle_ff - 16'd1;
   assign hidx      = handle_m1[IDX_W-1:0];
   assign h_in_range = (handle_ff != 16'd0) && (handle_ff <= 16'(HANDLES));
   assign idx_p1    = HH_W'(idx_ff) + HH_W'(1);

   always_comb begin
      unique case (uw.cond)
         C_NONE:       taken = 1'b0;
         C_TOO_BIG:    taken = size_ff > free_kb;
         C_SLOT_FREE:  taken = !valid_ff[idx_ff];
         C_SCAN_LAST:  taken = idx_ff == IDX_W'(HANDLES - 1);
         C_FREE_BAD:   taken = (handle_ff == 16'd0) || (handle_ff > 16'(high_ff));
         C_BAD_HANDLE: taken = !(h_in_range && valid_ff[hidx]);
         C_LOCK_ZERO:  taken = rd_lock_ff == 8'd0;
         default:      taken = 1'b0;
      endcase
   end

   // reply word for the current step
   always_comb begin
      ax_in   = 16'd0;
      bl_in   = 8'd0;
      bh_in   = 8'd0;
      dx_in   = 16'd0;
      mask_in = M_AX | M_BL;
      unique case (uw.op)
         U_VERSION: begin
            ax_in   = XMS_VERSION;
            mask_in = M_AX | M_BL | M_BH | M_DX;
         end
         U_HMA:        bl_in = ERR_NO_HMA;
         U_A20_ON: begin
            ax_in   = 16'd1;
            mask_in = M_AX;
         end
         U_A20_OFF: begin
            ax_in = 16'd1;
            bl_in = ERR_A20_ON;
         end
         U_QUERY_A20:  ax_in = 16'd1;
         U_QUERY_FREE: begin
            ax_in   = free_kb;
            dx_in   = free_kb;
            mask_in = M_AX | M_BL | M_DX;
         end
         U_TOO_BIG:    bl_in = ERR_NO_MEM;
         U_FULL:       bl_in = ERR_NO_HANDLE;
         U_BAD_HANDLE: bl_in = ERR_BAD_HANDLE;
         U_NOT_LOCKED: bl_in = ERR_NOT_LOCKED;
         U_ALLOC: begin
            ax_in   = 16'd1;
            dx_in   = 16'(idx_p1);
            mask_in = M_AX | M_BL | M_DX;
         end
         U_FREE:       ax_in = 16'd1;
         U_LOCK: begin
            ax_in   = 16'd1;
            dx_in   = 16'd1;
            mask_in = M_AX | M_BL | M_BH | M_DX;
         end
         U_UNLOCK, U_RESIZE: begin
            ax_in   = 16'd1;
            mask_in = M_AX;
         end
         U_INFO: begin
            ax_in   = 16'd1;
            bl_in   = INFO_FREE_BYTE;
            bh_in   = rd_lock_ff;
            dx_in   = rd_size_ff;
            mask_in = M_AX | M_BL | M_BH | M_DX;
         end
         default:      bl_in = ERR_BAD_FN;
      endcase
   end

   // sequencer and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= PC_VERSION;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         used_kb_ff   <= 16'd0;
         high_ff      <= '0;
         total_kb_ff  <= TOTAL_KB_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            total_kb_ff <= csr_total_kb;
         end
         if (exec && uw.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_take) begin
            busy_ff <= 1'b1;
            pc_ff   <= dispatch(req_command);
         end else if (exec) begin
            pc_ff <= taken ? uw.target : uw.next;
            if (uw.done) begin
               busy_ff <= 1'b0;
            end
            unique case (uw.op)
               U_ALLOC: begin
                  valid_ff[idx_ff] <= 1'b1;
                  used_kb_ff       <= used_kb_ff + size_ff;
                  if (idx_p1 > high_ff) begin
                     high_ff <= idx_p1;
                  end
               end
               U_FREE: begin
                  if (valid_ff[hidx]) begin
                     used_kb_ff <= used_kb_ff - rd_size_ff;
                  end
                  valid_ff[hidx] <= 1'b0;
               end
               U_RESIZE:  used_kb_ff <= used_kb_ff + size_ff - rd_size_ff;
               default:   ;
            endcase
         end
      end
   end

   // request capture, scan index and reply word
   always_ff @(posedge clock) begin
      if (req_take) begin
         handle_ff <= req_handle;
         size_ff   <= req_size_kb;
      end
      if (exec) begin
         if (uw.op == U_IDX_CLR) begin
            idx_ff <= '0;
         end else if (uw.op == U_IDX_INC) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (uw.done) begin
            ax_ff   <= ax_in;
            bl_ff   <= bl_in;
            bh_ff   <= bh_in;
            dx_ff   <= dx_in;
            mask_ff <= mask_in;
         end
      end
   end

   // block size and lock count tables
   always_ff @(posedge clock) begin
      rd_size_ff <= size_mem[hidx];
      rd_lock_ff <= lock_mem[hidx];
      if (exec) begin
         unique case (uw.op)
            U_ALLOC: begin
               size_mem[idx_ff] <= size_ff;
               lock_mem[idx_ff] <= 8'd0;
            end
            U_LOCK: begin
               if (rd_lock_ff != LOCK_MAX) begin
                  lock_mem[hidx] <= rd_lock_ff + 8'd1;
               end
            end
            U_UNLOCK: lock_mem[hidx] <= rd_lock_ff - 8'd1;
            U_RESIZE: size_mem[hidx] <= size_ff;
            default:  ;
         endcase
      end
   end

   assign req_stall      = busy_ff;
   assign csr_ready      = !busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ax_out     = ax_ff;
   assign rsp_bl_out     = bl_ff;
   assign rsp_bh_out     = bh_ff;
   assign rsp_dx_out     = dx_ff;
   assign rsp_write_mask = mask_ff;

endmodule

/* hw/rtl/ememh_checker.sv */
// port checker for the extended memory handle manager and its bind
module ememh_checker
   import ememh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_ax_out,
   input logic [7:0]  rsp_bl_out,
   input logic [7:0]  rsp_bh_out,
   input logic [15:0] rsp_dx_out,
   input logic [3:0]  rsp_write_mask,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("reply word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_ax_out) && $stable(rsp_dx_out)
                                 && $stable(rsp_bl_out) && $stable(rsp_bh_out)
                                 && $stable(rsp_write_mask))
      else $error("stalled reply word changed");

   a_ax_written: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_write_mask & M_AX) == M_AX)
      else $error("reply without ax");

   a_masked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_write_mask & M_DX) == M_DX) || rsp_dx_out == 16'd0)
                    && (((rsp_write_mask & M_BH) == M_BH) || rsp_bh_out == 8'd0))
      else $error("unwritten reply field not zero");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !csr_ready)
      else $error("config port open while a request runs");

endmodule

bind extended_memory_handle_manager_top ememh_checker u_ememh_checker (.*);
